>>> rtl/swcrc_pkg.sv
// ----------------------------------------------------------------------------
// swcrc_pkg: shared definitions for the selectable-width CRC core
// Width codes, polynomials, register indexes and width helper functions.
// ----------------------------------------------------------------------------
package swcrc_pkg;

    // Widest CRC that this build supports (8 to 32).
    localparam int unsigned MAX_WIDTH = 32;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SELECT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE  = 1'b1;

    // Width select codes as written by software.
    localparam logic [1:0] SEL_CRC8  = 2'd0;
    localparam logic [1:0] SEL_CRC14 = 2'd1;
    localparam logic [1:0] SEL_CRC32 = 2'd2;

    // Polynomials without their leading one.
    localparam logic [7:0]  POLY_8  = 8'h2F;
    localparam logic [13:0] POLY_14 = 14'h2E57;
    localparam logic [31:0] POLY_32 = 32'h04C1_1DB7;

    typedef enum logic [1:0] {
        WIDTH_8,
        WIDTH_14,
        WIDTH_32
    } t_width;

    // Decodes the select code and falls back to the widest CRC the build holds.
    function automatic t_width eff_width(input logic [1:0] code);
        t_width w;
        case (code)
            SEL_CRC8:  w = WIDTH_8;
            SEL_CRC14: w = WIDTH_14;
            default:   w = WIDTH_32;
        endcase
        if (w == WIDTH_32 && MAX_WIDTH < 32) begin
            w = WIDTH_14;
        end
        if (w == WIDTH_14 && MAX_WIDTH < 14) begin
            w = WIDTH_8;
        end
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] width_mask(input t_width w);
        logic [DATA_W-1:0] m;
        case (w)
            WIDTH_8:  m = 32'h0000_00FF;
            WIDTH_14: m = 32'h0000_3FFF;
            default:  m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/swcrc_step.sv
// ----------------------------------------------------------------------------
// swcrc_step: one-byte CRC update
// Folds one message byte, MSB first, into the running CRC of the chosen width.
// ----------------------------------------------------------------------------
module swcrc_step (
    input  swcrc_pkg::t_width i_width,
    input  logic [31:0]       i_accum,
    input  logic [7:0]        i_data,
    output logic [31:0]       o_accum
);
    import swcrc_pkg::*;

    logic [7:0]  c8;
    logic [13:0] c14;
    logic [31:0] c32;

    always_comb begin
        c8  = i_accum[7:0] ^ i_data;
        c14 = i_accum[13:0] ^ {i_data, 6'b0};
        c32 = i_accum ^ {i_data, 24'b0};
        for (int b = 0; b < 8; b++) begin
            c8  = {c8[6:0], 1'b0} ^ (c8[7] ? POLY_8 : 8'h00);
            c14 = {c14[12:0], 1'b0} ^ (c14[13] ? POLY_14 : 14'h0000);
            c32 = {c32[30:0], 1'b0} ^ (c32[31] ? POLY_32 : 32'h0000_0000);
        end
    end

    always_comb begin
        case (i_width)
            WIDTH_8:  o_accum = {24'b0, c8};
            WIDTH_14: o_accum = {18'b0, c14};
            default:  o_accum = c32;
        endcase
    end

endmodule

>>> rtl/selectable_width_crc_core.sv
// ----------------------------------------------------------------------------
// selectable_width_crc_core: byte-wide MSB-first CRC-8/14/32 engine
// Non-reflected CRC with no final XOR over a byte stream, width chosen by a
// configuration register.
// ----------------------------------------------------------------------------
// Usage:
// Software selects the width (0 = CRC-8, 1 = CRC-14, 2 or 3 = CRC-32) and the
// start value through the write port while the block is idle. Every write to
// either register also reloads the running CRC, so it starts a fresh message.
// Message bytes arrive on the input channel, one request per byte, with
// last_byte marking the end of a message. Only the last byte yields a result
// request carrying the finished CRC, zero-extended to 32 bits; the running CRC
// then reloads the start value for the next message.
// Throughput is one byte per cycle while the input does not stall. A byte is
// captured in an input register, from which the eight shift-XOR steps update
// the running CRC and, for a last byte, the result register.
// Reset selects CRC-32 with a zero start value and empties both registers.
// While the receiver stalls a pending result, the result holds; non-last
// bytes keep flowing, and the input stalls only when a second last byte
// waits behind the held result.
// ----------------------------------------------------------------------------
module selectable_width_crc_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swcrc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swcrc_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_data_byte,
    input  logic                                i_last_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [31:0]                         o_crc_value
);
    import swcrc_pkg::*;

    // Configuration registers and running CRC.
    logic [1:0]        r_width_code;
    logic [DATA_W-1:0] r_start;
    logic [DATA_W-1:0] r_accum;
    t_width            width;
    logic [DATA_W-1:0] mask;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // Result register.
    logic              r_out_valid;
    logic [31:0]       r_out_crc;

    logic              fire;
    logic              out_free;
    logic [DATA_W-1:0] n_accum;
    logic [1:0]        n_width_code;
    logic [DATA_W-1:0] n_start;

    assign width = eff_width(r_width_code);
    assign mask  = width_mask(width);

    swcrc_step u_step (
        .i_width (width),
        .i_accum (r_accum),
        .i_data  (r_in_data),
        .o_accum (n_accum)
    );

    // The result register is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    // A held byte is processed unless it is a last byte with nowhere to go.
    assign fire       = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !fire;

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

    // Register values after a write, used to reload the running CRC.
    always_comb begin
        n_width_code = r_width_code;
        n_start      = r_start;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH_SELECT: n_width_code = i_cfg_data[1:0];
                REG_START_VALUE:  n_start      = i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_code <= SEL_CRC32;
            r_start      <= '0;
            r_accum      <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_width_code <= n_width_code;
            r_start      <= n_start;

            // Input register takes a byte whenever it is not stalling.
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end

            if (i_cfg_we) begin
                r_accum <= n_start & width_mask(eff_width(n_width_code));
            end else if (fire) begin
                if (r_in_last) begin
                    r_accum <= r_start & mask;
                end else begin
                    r_accum <= n_accum;
                end
            end

            if (fire && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (fire && r_in_last) begin
            r_out_crc <= n_accum;
        end
    end

endmodule

>>> rtl/swcrc_checker.sv
// ----------------------------------------------------------------------------
// swcrc_checker: port-level checks for the selectable-width CRC core
// Watches the handshakes at the top level and is bound to it.
// ----------------------------------------------------------------------------
module swcrc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [31:0]                     o_crc_value
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_crc_value))
        else $error("result value changed while stalled");

    // The input only backs up behind a result the receiver is holding off.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // Reset empties the block.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

endmodule

bind selectable_width_crc_core swcrc_checker u_swcrc_checker (.*);
